>>> rtl/pidd_pkg.sv
// Shared types and constants for the delayed-derivative PID controller.
// Used by the top level, the arithmetic pipeline and the port checker.
// No dependencies.
package pidd_pkg;

  // Parameter defaults
  localparam int DepthDefault   = 4;
  localparam int DivisorDefault = 1000;

  // Configuration port
  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 31;

  localparam logic [CfgIndexW-1:0] CfgGainP    = 3'd0;
  localparam logic [CfgIndexW-1:0] CfgGainI    = 3'd1;
  localparam logic [CfgIndexW-1:0] CfgGainD    = 3'd2;
  localparam logic [CfgIndexW-1:0] CfgLimit    = 3'd3;
  localparam logic [CfgIndexW-1:0] CfgUseDelay = 3'd4;

  // Register values after reset
  localparam logic [15:0] GainPReset    = 16'd100;
  localparam logic [15:0] GainIReset    = 16'd0;
  localparam logic [15:0] GainDReset    = 16'd0;
  localparam logic [30:0] LimitReset    = 31'd32767;
  localparam logic        UseDelayReset = 1'b1;

  // Operation codes
  localparam logic OpStep  = 1'b0;
  localparam logic OpClear = 1'b1;

  // Input beat
  typedef struct packed {
    logic               op;
    logic signed [15:0] error;
  } pidd_in_t;

  // Result beat
  typedef struct packed {
    logic signed [31:0] control;
    logic signed [31:0] integral_term;
    logic signed [15:0] derivative_term;
  } pidd_out_t;

  // Terms that ride along the arithmetic pipeline
  typedef struct packed {
    logic signed [31:0] integral;
    logic signed [15:0] deriv;
  } pidd_side_t;

  // Operands handed from the state stage to the arithmetic pipeline
  typedef struct packed {
    logic signed [15:0] error;
    pidd_side_t         side;
  } pidd_ops_t;

endpackage

>>> rtl/pidd_arith.sv
// Gain multiply, sum and divide-by-constant pipeline of the PID controller.
// Six register stages, each with its own valid; depends on pidd_pkg.
// Divide uses an exact reciprocal multiply on the magnitude, then restores sign.
module pidd_arith #(
  parameter int DIVISOR = pidd_pkg::DivisorDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                ops_valid,
  output logic                ops_stall,
  input  pidd_pkg::pidd_ops_t ops,
  input  logic [15:0]         gain_p,
  input  logic [15:0]         gain_i,
  input  logic [15:0]         gain_d,
  output logic                res_valid,
  input  logic                res_stall,
  output pidd_pkg::pidd_out_t res
);
  import pidd_pkg::*;

  // Reciprocal: ceil(2^(32+l) / DIVISOR) with l = ceil(log2 DIVISOR); exact for 32-bit values
  localparam int          DivShift = $clog2(DIVISOR);
  localparam logic [63:0] RecipNum = 64'd1 << (32 + DivShift);
  localparam logic [32:0] Recip    = 33'((RecipNum + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
  localparam int          QShift   = 32 + DivShift;

  // Stage valids and readiness
  logic m_valid, a_valid, s_valid, p_valid, q_valid;
  logic ready_m, ready_a, ready_s, ready_p, ready_q, ready_o;

  // Stage payloads
  logic [31:0] prod_p, prod_i, prod_d;
  pidd_side_t  m_side, a_side, s_side, p_side, q_side;
  logic [31:0] acc;
  logic        s_neg, p_neg, q_neg;
  logic [31:0] mag;
  logic [48:0] part_hi, part_lo;
  logic [31:0] quo;

  // Combinational products and sums
  logic signed [32:0] prod_p_full, prod_d_full;
  logic [47:0]        prod_i_full;
  logic [31:0]        acc_next;
  logic [31:0]        mag_next;
  logic [64:0]        full_prod;
  logic [64:0]        quo_wide;

  assign ready_o   = !res_valid || !res_stall;
  assign ready_q   = !q_valid || ready_o;
  assign ready_p   = !p_valid || ready_q;
  assign ready_s   = !s_valid || ready_p;
  assign ready_a   = !a_valid || ready_s;
  assign ready_m   = !m_valid || ready_a;
  assign ops_stall = !ready_m;

  assign prod_p_full = ops.error * $signed({1'b0, gain_p});
  assign prod_d_full = ops.side.deriv * $signed({1'b0, gain_d});
  assign prod_i_full = $unsigned(ops.side.integral) * gain_i;

  assign acc_next  = prod_p + prod_i + prod_d;
  assign mag_next  = acc[31] ? (32'd0 - acc) : acc;
  assign full_prod = {part_hi, 16'd0} + {16'd0, part_lo};
  assign quo_wide  = full_prod >> QShift;

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid   <= 1'b0;
      a_valid   <= 1'b0;
      s_valid   <= 1'b0;
      p_valid   <= 1'b0;
      q_valid   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (ready_m) m_valid <= ops_valid;
      if (ready_a) a_valid <= m_valid;
      if (ready_s) s_valid <= a_valid;
      if (ready_p) p_valid <= s_valid;
      if (ready_q) q_valid <= p_valid;
      if (ready_o) res_valid <= q_valid;
    end
  end

  // Advance stage payloads
  always_ff @(posedge clk) begin
    // products, wrapped to 32 bits
    if (ready_m) begin
      prod_p <= prod_p_full[31:0];
      prod_i <= prod_i_full[31:0];
      prod_d <= prod_d_full[31:0];
      m_side <= ops.side;
    end
    // weighted sum
    if (ready_a) begin
      acc    <= acc_next;
      a_side <= m_side;
    end
    // split sign and magnitude
    if (ready_s) begin
      s_neg  <= acc[31];
      mag    <= mag_next;
      s_side <= a_side;
    end
    // reciprocal partial products
    if (ready_p) begin
      part_hi <= mag[31:16] * Recip;
      part_lo <= mag[15:0] * Recip;
      p_neg   <= s_neg;
      p_side  <= s_side;
    end
    // combine and shift out the quotient
    if (ready_q) begin
      quo    <= quo_wide[31:0];
      q_neg  <= p_neg;
      q_side <= p_side;
    end
    // restore sign, truncating toward zero
    if (ready_o) begin
      res.control         <= q_neg ? $signed(32'd0 - quo) : $signed(quo);
      res.integral_term   <= q_side.integral;
      res.derivative_term <= q_side.deriv;
    end
  end

endmodule

>>> rtl/pid_controller_delayed_derivative.sv
// PID controller with clamped integral and a delayed derivative, top level.
// Holds the configuration registers, the loop state and the error history memory;
// depends on pidd_pkg and pidd_arith.
//
// Usage:
//   sample / sample_valid / sample_stall carry one beat per control step: op selects
//   a control step or a clear of all loop state, error is the signed sample.
//   result / result_valid / result_stall carry exactly one beat per accepted sample,
//   in order: control, the clamped integral and the wrapped derivative.
//   cfg_we / cfg_index / cfg_data write one register per cycle; write only while idle.
// A result is valid once its sample has passed the state stage and every stage of pidd_arith.
// Throughput: one sample per cycle while sample_stall is low, set by the single
//   read port of the history memory, which is read at the accepting edge;
//   back-to-back writes to the entry just read are forwarded.
// Reset: configuration returns to its defaults, integral and previous error go to
//   zero, the history pointer to entry 0 and every history entry is marked empty
//   (an empty entry reads as zero). A clear beat does the same for the loop state
//   but keeps the configuration. No clearing pass is needed.
// Stall: while result_stall holds, the pipeline keeps filling its empty stages;
//   once every stage is full, sample_stall rises and nothing is lost.
module pid_controller_delayed_derivative #(
  parameter int DEPTH   = pidd_pkg::DepthDefault,
  parameter int DIVISOR = pidd_pkg::DivisorDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  pidd_pkg::pidd_in_t            sample,
  output logic                          result_valid,
  input  logic                          result_stall,
  output pidd_pkg::pidd_out_t           result,
  input  logic                          cfg_we,
  input  logic [pidd_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [pidd_pkg::CfgDataW-1:0]  cfg_data
);
  import pidd_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Configuration registers
  logic [15:0] gain_p, gain_i, gain_d;
  logic [30:0] integral_limit;
  logic        use_delay_line;

  // Loop state
  logic signed [31:0] error_sum;
  logic signed [15:0] previous_error;
  logic [PtrW-1:0]    ptr;
  logic [DEPTH-1:0]   hist_valid;
  logic [15:0]        hist_mem [DEPTH];
  logic [15:0]        hist_rd;
  logic               fwd_hit;
  logic [15:0]        fwd_data;

  // State stage
  logic            s1_valid;
  pidd_in_t        s1_data;
  logic [PtrW-1:0] s1_ptr;

  // Handshake
  logic accept, commit, commit_step, ops_stall;
  logic [PtrW-1:0] ptr_next;

  // State stage arithmetic
  logic signed [32:0] sum_wide, lim_pos, lim_neg, isum_wide;
  logic signed [15:0] hist_ref, deriv_ref, deriv;
  pidd_ops_t          ops;

  assign sample_stall = s1_valid && ops_stall;
  assign accept       = sample_valid && !sample_stall;
  assign commit       = s1_valid && !ops_stall;
  assign commit_step  = commit && (s1_data.op == OpStep);
  assign ptr_next     = (ptr == PtrW'(DEPTH - 1)) ? '0 : ptr + 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p         <= GainPReset;
      gain_i         <= GainIReset;
      gain_d         <= GainDReset;
      integral_limit <= LimitReset;
      use_delay_line <= UseDelayReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgGainP:    gain_p         <= cfg_data[15:0];
        CfgGainI:    gain_i         <= cfg_data[15:0];
        CfgGainD:    gain_d         <= cfg_data[15:0];
        CfgLimit:    integral_limit <= cfg_data;
        CfgUseDelay: use_delay_line <= cfg_data[0];
        default:     ;
      endcase
    end
  end

  // Capture accepted beat and advance the history pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      ptr      <= '0;
    end else begin
      if (!sample_stall) s1_valid <= sample_valid;
      if (accept) ptr <= (sample.op == OpClear) ? '0 : ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_data <= sample;
      s1_ptr  <= ptr;
    end
  end

  // History memory: read on accept, write back on a committed step; forward same-entry overlap
  always_ff @(posedge clk) begin
    if (commit_step) hist_mem[s1_ptr] <= s1_data.error;
    if (accept) begin
      hist_rd  <= hist_mem[ptr];
      fwd_hit  <= commit_step && (s1_ptr == ptr);
      fwd_data <= s1_data.error;
    end
  end

  // Empty-entry marks
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_valid <= '0;
    end else if (commit) begin
      if (s1_data.op == OpClear) hist_valid <= '0;
      else hist_valid[s1_ptr] <= 1'b1;
    end
  end

  // Clamp the integral
  assign sum_wide = {error_sum[31], error_sum} + {{17{s1_data.error[15]}}, s1_data.error};
  assign lim_pos  = {2'b00, integral_limit};
  assign lim_neg  = 33'sd0 - lim_pos;

  always_comb begin
    if (sum_wide > lim_pos) isum_wide = lim_pos;
    else if (sum_wide < lim_neg) isum_wide = lim_neg;
    else isum_wide = sum_wide;
  end

  // Pick the derivative reference
  assign hist_ref  = hist_valid[s1_ptr] ? $signed(fwd_hit ? fwd_data : hist_rd) : 16'sd0;
  assign deriv_ref = use_delay_line ? hist_ref : previous_error;
  assign deriv     = s1_data.error - deriv_ref;

  // Hand operands down; a clear beat yields all-zero terms
  always_comb begin
    if (s1_data.op == OpClear) begin
      ops = '0;
    end else begin
      ops.error         = s1_data.error;
      ops.side.integral = isum_wide[31:0];
      ops.side.deriv    = deriv;
    end
  end

  // Update the integral and previous error
  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum      <= '0;
      previous_error <= '0;
    end else if (commit) begin
      if (s1_data.op == OpClear) begin
        error_sum      <= '0;
        previous_error <= '0;
      end else begin
        error_sum      <= isum_wide[31:0];
        previous_error <= s1_data.error;
      end
    end
  end

  pidd_arith #(
    .DIVISOR(DIVISOR)
  ) u_arith (
    .clk      (clk),
    .rst      (rst),
    .ops_valid(s1_valid),
    .ops_stall(ops_stall),
    .ops      (ops),
    .gain_p   (gain_p),
    .gain_i   (gain_i),
    .gain_d   (gain_d),
    .res_valid(result_valid),
    .res_stall(result_stall),
    .res      (result)
  );

endmodule

>>> rtl/pidd_chk.sv
// Port-level checks for the delayed-derivative PID controller.
// Watches the top level's channels only; depends on pidd_pkg; bound below.
module pidd_chk (
  input logic                clk,
  input logic                rst,
  input logic                sample_valid,
  input logic                sample_stall,
  input logic                result_valid,
  input logic                result_stall,
  input pidd_pkg::pidd_out_t result
);

  // Hold a stalled result beat
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result beat dropped while stalled");

  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result))
    else $error("result payload changed while stalled");

  // Drop all results on reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  // Back-pressure on input only when the output is backed up
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> result_valid && result_stall)
    else $error("input stalled while output is free");

  // Result valid is known after an accepted sample
  a_valid_known: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> !$isunknown(result_valid))
    else $error("result valid unknown after accept");

endmodule

bind pid_controller_delayed_derivative pidd_chk u_chk (
  .clk         (clk),
  .rst         (rst),
  .sample_valid(sample_valid),
  .sample_stall(sample_stall),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .result      (result)
);
